FILE: rtl/rsi_pkg.sv
// Shared types and constants for the relative strength index block.
package rsi_pkg;

    localparam int MAX_PERIOD = 64;
    localparam int PRICE_BITS = 32;
    localparam int SLOT_BITS  = $clog2(MAX_PERIOD);
    localparam int CNT_BITS   = $clog2(MAX_PERIOD + 2);
    localparam int SUM_BITS   = PRICE_BITS + SLOT_BITS;
    localparam int TOT_BITS   = SUM_BITS + 1;
    localparam int MUL_BITS   = SUM_BITS + 6;
    localparam int REM_BITS   = SUM_BITS + 17;
    localparam int DSH_BITS   = TOT_BITS + 15;
    localparam int RSI_BITS   = 15;
    localparam int STEP_BITS  = 4;
    localparam int CFG_BITS   = 7;

    localparam logic [CFG_BITS-1:0]  PERIOD_RESET = CFG_BITS'(14);
    localparam logic [RSI_BITS-1:0]  RSI_FULL     = RSI_BITS'(25600);
    localparam logic [STEP_BITS-1:0] LAST_STEP    = STEP_BITS'(RSI_BITS - 1);

    // One queued item: window sums and the ready flag
    typedef struct packed {
        logic [SUM_BITS-1:0] gain;
        logic [SUM_BITS-1:0] loss;
        logic                ready;
    } rsi_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } rsi_q_status_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIFF,
        F_SUM
    } rsi_front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SUM,
        B_PREP,
        B_DIV,
        B_OUT
    } rsi_back_state_t;

endpackage

FILE: rtl/rsi_front.sv
// Front end: takes prices, keeps the difference ring and the window sums.
module rsi_front
    import rsi_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [PRICE_BITS-1:0] s_tdata,
    input  logic                  s_tuser,
    input  logic                  cfg_we,
    input  logic [CFG_BITS-1:0]   cfg_wdata,
    input  rsi_q_status_t         q_status,
    output logic                  push,
    output rsi_entry_t            push_entry
);

    rsi_front_state_t state_reg, state_next;

    logic [CNT_BITS-1:0]   period_reg, period_next;
    logic [PRICE_BITS-1:0] last_reg, last_next;
    logic [PRICE_BITS-1:0] price_reg, price_next;
    logic [SUM_BITS-1:0]   gain_reg, gain_next;
    logic [SUM_BITS-1:0]   loss_reg, loss_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic [SLOT_BITS-1:0]  slot_reg, slot_next;
    logic                  new_neg_reg, new_neg_next;
    logic [PRICE_BITS-1:0] new_mag_reg, new_mag_next;
    logic                  old_use_reg, old_use_next;
    logic [PRICE_BITS:0]   rd_reg;
    logic                  ring_we;
    logic                  accept;
    logic [PRICE_BITS-1:0] add_gain, add_loss, sub_gain, sub_loss;

    // Ring of stored differences: sign and magnitude
    logic [PRICE_BITS:0] ring_mem [MAX_PERIOD];

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == F_IDLE) && !q_status.full;

    always_comb begin
        add_gain = new_neg_reg ? '0 : new_mag_reg;
        add_loss = new_neg_reg ? new_mag_reg : '0;
        sub_gain = (old_use_reg && !rd_reg[PRICE_BITS]) ? rd_reg[PRICE_BITS-1:0] : '0;
        sub_loss = (old_use_reg && rd_reg[PRICE_BITS]) ? rd_reg[PRICE_BITS-1:0] : '0;
    end

    // Next state and datapath updates
    always_comb begin
        state_next   = state_reg;
        period_next  = period_reg;
        last_next    = last_reg;
        price_next   = price_reg;
        gain_next    = gain_reg;
        loss_next    = loss_reg;
        count_next   = count_reg;
        slot_next    = slot_reg;
        new_neg_next = new_neg_reg;
        new_mag_next = new_mag_reg;
        old_use_next = old_use_reg;
        ring_we      = 1'b0;
        push         = 1'b0;
        case (state_reg)
            F_IDLE: begin
                // Period write clears the history
                if (cfg_we) begin
                    if (cfg_wdata == '0) begin
                        period_next = CNT_BITS'(1);
                    end else if (CNT_BITS'(cfg_wdata) > CNT_BITS'(MAX_PERIOD)) begin
                        period_next = CNT_BITS'(MAX_PERIOD);
                    end else begin
                        period_next = CNT_BITS'(cfg_wdata);
                    end
                    last_next  = '0;
                    gain_next  = '0;
                    loss_next  = '0;
                    count_next = '0;
                    slot_next  = '0;
                end
                if (accept) begin
                    price_next = s_tdata;
                    if (s_tuser) begin
                        last_next  = '0;
                        gain_next  = '0;
                        loss_next  = '0;
                        count_next = '0;
                        slot_next  = '0;
                    end
                    state_next = F_DIFF;
                end
            end
            F_DIFF: begin
                // Form the new difference and advance the ring
                if (count_reg <= period_reg) begin
                    count_next = count_reg + CNT_BITS'(1);
                end
                last_next = price_reg;
                if (count_reg != '0) begin
                    ring_we      = 1'b1;
                    new_neg_next = price_reg < last_reg;
                    new_mag_next = (price_reg < last_reg) ? last_reg - price_reg
                                                          : price_reg - last_reg;
                    old_use_next = count_reg > period_reg;
                    if (CNT_BITS'(slot_reg) + CNT_BITS'(1) >= period_reg) begin
                        slot_next = '0;
                    end else begin
                        slot_next = slot_reg + SLOT_BITS'(1);
                    end
                end else begin
                    new_neg_next = 1'b0;
                    new_mag_next = '0;
                    old_use_next = 1'b0;
                end
                state_next = F_SUM;
            end
            F_SUM: begin
                // Drop the oldest difference, add the newest, hand on the sums
                gain_next  = gain_reg + SUM_BITS'(add_gain) - SUM_BITS'(sub_gain);
                loss_next  = loss_reg + SUM_BITS'(add_loss) - SUM_BITS'(sub_loss);
                push       = 1'b1;
                state_next = F_IDLE;
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    assign push_entry.gain  = gain_next;
    assign push_entry.loss  = loss_next;
    assign push_entry.ready = count_reg > period_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= F_IDLE;
            period_reg <= CNT_BITS'(PERIOD_RESET);
            last_reg   <= '0;
            gain_reg   <= '0;
            loss_reg   <= '0;
            count_reg  <= '0;
            slot_reg   <= '0;
        end else begin
            state_reg  <= state_next;
            period_reg <= period_next;
            last_reg   <= last_next;
            gain_reg   <= gain_next;
            loss_reg   <= loss_next;
            count_reg  <= count_next;
            slot_reg   <= slot_next;
        end
    end

    always_ff @(posedge aclk) begin
        price_reg   <= price_next;
        new_neg_reg <= new_neg_next;
        new_mag_reg <= new_mag_next;
        old_use_reg <= old_use_next;
    end

    // Ring write and registered read of the slot about to be replaced
    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring_mem[slot_reg] <= {new_neg_next, new_mag_next};
        end
        if (accept) begin
            rd_reg <= ring_mem[slot_reg];
        end
    end

endmodule

FILE: rtl/rsi_queue.sv
// Two-entry queue between the front end and the divider.
module rsi_queue
    import rsi_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  rsi_entry_t    push_entry,
    input  logic          pop,
    output rsi_entry_t    pop_entry,
    output rsi_q_status_t status
);

    rsi_entry_t  entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  fill_reg, fill_next;

    assign status.full  = fill_reg == 2'd2;
    assign status.empty = fill_reg == 2'd0;
    assign pop_entry    = entry_reg[rd_ptr_reg];

    // Advance pointers and fill level
    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: rtl/rsi_back.sv
// Back end: scaled ratio by restoring division and the output register.
module rsi_back
    import rsi_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  rsi_q_status_t       q_status,
    input  rsi_entry_t          pop_entry,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_tdata,
    output logic                m_tuser
);

    rsi_back_state_t state_reg, state_next;

    logic [SUM_BITS-1:0]  gain_reg, gain_next;
    logic [SUM_BITS-1:0]  loss_reg, loss_next;
    logic                 ready_reg, ready_next;
    logic [TOT_BITS-1:0]  tot_reg, tot_next;
    logic [MUL_BITS-1:0]  mul_reg, mul_next;
    logic [REM_BITS-1:0]  rem_reg, rem_next;
    logic [DSH_BITS-1:0]  dsh_reg, dsh_next;
    logic [RSI_BITS-1:0]  quo_reg, quo_next;
    logic [STEP_BITS-1:0] step_reg, step_next;
    logic                 out_valid_reg, out_valid_next;
    logic [RSI_BITS-1:0]  out_rsi_reg, out_rsi_next;
    logic                 out_ready_reg, out_ready_next;
    logic                 out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        state_next     = state_reg;
        gain_next      = gain_reg;
        loss_next      = loss_reg;
        ready_next     = ready_reg;
        tot_next       = tot_reg;
        mul_next       = mul_reg;
        rem_next       = rem_reg;
        dsh_next       = dsh_reg;
        quo_next       = quo_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_rsi_next   = out_rsi_reg;
        out_ready_next = out_ready_reg;
        pop            = 1'b0;
        case (state_reg)
            B_IDLE: begin
                // Take the next item; short cases skip the divider
                if (!q_status.empty) begin
                    pop        = 1'b1;
                    gain_next  = pop_entry.gain;
                    loss_next  = pop_entry.loss;
                    ready_next = pop_entry.ready;
                    if (!pop_entry.ready) begin
                        quo_next   = '0;
                        state_next = B_OUT;
                    end else if (pop_entry.loss == '0) begin
                        quo_next   = RSI_FULL;
                        state_next = B_OUT;
                    end else begin
                        state_next = B_SUM;
                    end
                end
            end
            B_SUM: begin
                // Total and gain times fifty
                tot_next   = TOT_BITS'(gain_reg) + TOT_BITS'(loss_reg);
                mul_next   = (MUL_BITS'(gain_reg) << 5) + (MUL_BITS'(gain_reg) << 4)
                           + (MUL_BITS'(gain_reg) << 1);
                state_next = B_PREP;
            end
            B_PREP: begin
                // Dividend 51200*g + t, divisor 2*t aligned to the top quotient bit
                rem_next   = (REM_BITS'(mul_reg) << 10) + REM_BITS'(tot_reg);
                dsh_next   = DSH_BITS'(tot_reg) << RSI_BITS;
                quo_next   = '0;
                step_next  = LAST_STEP;
                state_next = B_DIV;
            end
            B_DIV: begin
                // One quotient bit per cycle
                if (rem_reg >= REM_BITS'(dsh_reg)) begin
                    rem_next = rem_reg - REM_BITS'(dsh_reg);
                    quo_next = {quo_reg[RSI_BITS-2:0], 1'b1};
                end else begin
                    quo_next = {quo_reg[RSI_BITS-2:0], 1'b0};
                end
                dsh_next  = dsh_reg >> 1;
                step_next = step_reg - STEP_BITS'(1);
                if (step_reg == '0) begin
                    state_next = B_OUT;
                end
            end
            B_OUT: begin
                // Hold until the output register is free
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_rsi_next   = quo_reg;
                    out_ready_next = ready_reg;
                    state_next     = B_IDLE;
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_rsi_reg};
    assign m_tuser  = out_ready_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        gain_reg      <= gain_next;
        loss_reg      <= loss_next;
        ready_reg     <= ready_next;
        tot_reg       <= tot_next;
        mul_reg       <= mul_next;
        rem_reg       <= rem_next;
        dsh_reg       <= dsh_next;
        quo_reg       <= quo_next;
        step_reg      <= step_next;
        out_rsi_reg   <= out_rsi_next;
        out_ready_reg <= out_ready_next;
    end

endmodule

FILE: rtl/relative_strength_index.sv
// A result passes from the front end through the queue to the back end; short cases skip the divider.
// The front end takes a new price only once it has finished the last one and while the queue
// is not full; a division yields one quotient bit a cycle over 15 bits.
// A two-entry queue lets the front end run ahead of the divider.
// Reset (aresetn low, synchronous) sets period to 14 and clears the history; the
// difference ring keeps its contents, and only slots written in the current series are read.
module relative_strength_index
    import rsi_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [PRICE_BITS-1:0] s_tdata,   // price
    input  logic                  s_tuser,   // series_start
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,   // rsi_value [14:0], zero [15]
    output logic                  m_tuser,   // ready_res
    input  logic                  cfg_we,
    input  logic [CFG_BITS-1:0]   cfg_wdata
);

    rsi_q_status_t q_status;
    rsi_entry_t    push_entry;
    rsi_entry_t    pop_entry;
    logic          push;
    logic          pop;

    rsi_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    rsi_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .status     (q_status)
    );

    rsi_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_status  (q_status),
        .pop_entry (pop_entry),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

FILE: rtl/rsi_checker.sv
// Port-level checks for the relative strength index block, bound to the top level.
module rsi_port_checks
    import rsi_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [15:0]           m_tdata,
    input logic                  m_tuser
);

    // Hold a stalled result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // A result before the window is full reads zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == 16'd0)
        else $error("non-zero value while not ready");

    // Value stays within 0..100
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata <= {1'b0, RSI_FULL})
        else $error("value above full scale");

    // Front end is busy in F_DIFF and F_SUM after taking an item
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
        else $error("item taken while front end busy");

endmodule

bind relative_strength_index rsi_port_checks u_rsi_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: tb/sv/rsi_checker.sv
// Checker for the relative strength index block: predicts each result and compares it.
`timescale 1ns / 1ps

module rsi_checker
    import rsi_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [PRICE_BITS-1:0] s_tdata,   // price
    input  logic                  s_tuser,   // series_start
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [15:0]           m_tdata,   // rsi_value [14:0], zero [15]
    input  logic                  m_tuser,   // ready_res
    input  logic                  cfg_we,
    input  logic [CFG_BITS-1:0]   cfg_wdata,
    output int                    mismatch_total,
    output int                    pending
);

    typedef struct packed {
        logic [RSI_BITS-1:0] rsi;
        logic                ready;
    } rsi_result_t;

    // Shadow of the block's window state
    logic [PRICE_BITS:0]   diff_ring [MAX_PERIOD];
    logic [PRICE_BITS-1:0] last_price;
    logic [63:0]           gain_sum;
    logic [63:0]           loss_sum;
    int                    sample_count;
    int                    write_slot;
    logic [CFG_BITS-1:0]   period_reg;

    rsi_result_t rsi_expect_q [$];

    function automatic void restart_series();
        last_price   = '0;
        gain_sum     = '0;
        loss_sum     = '0;
        sample_count = 0;
        write_slot   = 0;
    endfunction

    // Add a difference to its sum, or take it back out when it leaves the window
    function automatic void book_diff(input logic [PRICE_BITS:0] diff, input bit add);
        logic [PRICE_BITS:0] neg_diff;
        logic [63:0]         mag;
        neg_diff = -diff;
        mag      = diff[PRICE_BITS] ? 64'(neg_diff) : 64'(diff);
        if (diff[PRICE_BITS]) begin
            loss_sum = add ? loss_sum + mag : loss_sum - mag;
        end else begin
            gain_sum = add ? gain_sum + mag : gain_sum - mag;
        end
    endfunction

    // Advance the window by one price and work out the RSI it gives
    function automatic rsi_result_t rsi_predict(input logic [PRICE_BITS-1:0] price,
                                                input logic start);
        rsi_result_t         res;
        int                  span;
        logic [PRICE_BITS:0] diff;
        logic [63:0]         total;
        res  = '0;
        // a period of zero behaves as one, anything past the ring as the ring size
        span = (period_reg == 0) ? 1 :
               (int'(period_reg) > MAX_PERIOD) ? MAX_PERIOD : int'(period_reg);
        if (start) begin
            restart_series();
        end
        if (sample_count == 0) begin
            sample_count = 1;
        end else begin
            diff = {1'b0, price} - {1'b0, last_price};
            if (sample_count > span) begin
                book_diff(diff_ring[write_slot], 1'b0);
            end
            diff_ring[write_slot] = diff;
            book_diff(diff, 1'b1);
            write_slot = (write_slot + 1 >= span) ? 0 : write_slot + 1;
            if (sample_count <= span) begin
                sample_count++;
            end
        end
        last_price = price;
        if (sample_count > span) begin
            res.ready = 1'b1;
            if (loss_sum == 0) begin
                res.rsi = RSI_FULL;
            end else begin
                // round to nearest, ties up
                total   = gain_sum + loss_sum;
                res.rsi = RSI_BITS'((64'd51200 * gain_sum + total) / (total << 1));
            end
        end
        return res;
    endfunction

    // Track register writes, predict accepted items, compare delivered results
    always @(posedge aclk) begin
        rsi_result_t want;
        if (!aresetn) begin
            period_reg = PERIOD_RESET;
            restart_series();
            rsi_expect_q.delete();
            mismatch_total = 0;
        end else begin
            if (cfg_we) begin
                period_reg = cfg_wdata;
                restart_series();
            end
            if (s_tvalid && s_tready) begin
                rsi_expect_q.push_back(rsi_predict(s_tdata, s_tuser));
            end
            if (m_tvalid && m_tready) begin
                if (rsi_expect_q.size() == 0) begin
                    $display("%0t: unexpected result: rsi %0d ready %0d",
                             $time, m_tdata, m_tuser);
                    mismatch_total++;
                end else begin
                    want = rsi_expect_q.pop_front();
                    if (m_tdata !== 16'(want.rsi)) begin
                        $display("%0t: rsi_value mismatch: expected %0d, got %0d",
                                 $time, want.rsi, m_tdata);
                        mismatch_total++;
                    end
                    if (m_tuser !== want.ready) begin
                        $display("%0t: ready_res mismatch: expected %0d, got %0d",
                                 $time, want.ready, m_tuser);
                        mismatch_total++;
                    end
                end
            end
        end
        pending = rsi_expect_q.size();
    end

endmodule

FILE: tb/sv/tb_relative_strength_index.sv
// Testbench top for the relative strength index block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_relative_strength_index;
    import rsi_pkg::*;

    typedef enum int {
        TREND_MIXED,
        TREND_UP,
        TREND_DOWN,
        TREND_FLAT
    } trend_t;

    localparam int PERIOD_RANDOM = -1;
    localparam int N_PHASES      = 10;
    localparam int SQUEEZE_LEN   = 300;
    localparam int DRAIN_TAIL    = 40;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [PRICE_BITS-1:0] s_tdata;   // price
    logic                  s_tuser;   // series_start
    logic                  m_tvalid;
    logic                  m_tready;
    logic [15:0]           m_tdata;   // rsi_value [14:0], zero [15]
    logic                  m_tuser;   // ready_res
    logic                  cfg_we;
    logic [CFG_BITS-1:0]   cfg_wdata;

    int mismatch_total;
    int pending;

    // Shared between the sender and the receiver
    bit                    tx_calm;
    bit                    rx_calm;
    bit                    squeeze;
    logic [PRICE_BITS-1:0] cur_price;
    trend_t                series_trend;

    int phase_period [N_PHASES] = '{1, 0, 3, MAX_PERIOD, 127, 65, 14, PERIOD_RANDOM, 2,
                                    PERIOD_RANDOM};
    int phase_items  [N_PHASES] = '{50, 40, 60, 120, 70, 70, 70, 70, 50, 40};

    relative_strength_index DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    rsi_checker u_rsi_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .mismatch_total (mismatch_total),
        .pending        (pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Mostly no gap, sometimes a few cycles, rarely a long one
    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 60) return 0;
        if (sel < 88) return $urandom_range(1, 3);
        if (sel < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Step the price along the current trend; now and then jump to an extreme
    function automatic logic [PRICE_BITS-1:0] walk_price();
        int                    sel;
        logic [PRICE_BITS-1:0] mag;
        bit                    down;
        sel = $urandom_range(0, 99);
        if (sel < 4) begin
            cur_price = ($urandom_range(0, 1) != 0) ? '1 : '0;
            return cur_price;
        end
        if (sel < 12 || (series_trend == TREND_FLAT && sel < 90)) begin
            mag = '0;
        end else if (sel < 55) begin
            mag = $urandom_range(1, 15);
        end else if (sel < 85) begin
            mag = $urandom_range(16, 65535);
        end else begin
            mag = $urandom();
        end
        case (series_trend)
            TREND_UP: begin
                down = 1'b0;
            end
            TREND_DOWN: begin
                down = 1'b1;
            end
            default: begin
                down = $urandom_range(0, 1);
            end
        endcase
        cur_price = down ? cur_price - mag : cur_price + mag;
        return cur_price;
    endfunction

    // Offer one item and hold it until taken
    task automatic send_item(input logic [PRICE_BITS-1:0] price, input logic start);
        int gap;
        s_tdata  <= price;
        s_tuser  <= start;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        gap = tx_calm ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Stop offering and wait until every expected result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic write_period(input logic [CFG_BITS-1:0] value);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // Result side: random stalls, plus one long hold when asked
    initial begin
        int rx_stall;
        int gap;
        rx_stall = 0;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (squeeze) begin
                squeeze  = 1'b0;
                rx_stall = SQUEEZE_LEN;
            end
            if (rx_stall > 0) begin
                m_tready <= 1'b0;
                rx_stall--;
            end else begin
                gap = rx_calm ? 0 : pick_gap();
                if (gap == 0) begin
                    m_tready <= 1'b1;
                end else begin
                    m_tready <= 1'b0;
                    rx_stall = gap - 1;
                end
            end
        end
    end

    // Stimulus and verdict
    initial begin
        int               ph;
        int               k;
        int               per;
        int               span;
        logic             start;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        tx_calm      = 1'b0;
        rx_calm      = 1'b0;
        squeeze      = 1'b0;
        cur_price    = '0;
        series_trend = TREND_MIXED;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset period: alternate full-scale losses and gains, ready on the fifteenth item
        send_item('1, 1'b1);
        for (k = 0; k < 15; k++) begin
            send_item(k[0] ? '1 : '0, 1'b0);
        end

        // Short window: balance, all loss, flat, gain only, a rounding tie, falling series
        drain();
        write_period(CFG_BITS'(2));
        send_item('0, 1'b1);
        send_item('1, 1'b0);
        send_item('0, 1'b0);
        send_item('0, 1'b0);
        send_item('0, 1'b0);
        send_item(PRICE_BITS'(1), 1'b0);
        send_item(PRICE_BITS'(2048), 1'b1);
        send_item(PRICE_BITS'(1), 1'b0);
        send_item(PRICE_BITS'(2), 1'b0);
        send_item('1, 1'b1);
        send_item(PRICE_BITS'(32'hFFFF_FFFE), 1'b0);
        send_item(PRICE_BITS'(32'hFFFF_FFFD), 1'b0);

        // Random walks over a range of window sizes
        for (ph = 0; ph < N_PHASES; ph++) begin
            drain();
            per  = (phase_period[ph] == PERIOD_RANDOM) ?
                   $urandom_range(1, MAX_PERIOD) : phase_period[ph];
            write_period(CFG_BITS'(per));
            span = (per == 0) ? 1 : (per > MAX_PERIOD) ? MAX_PERIOD : per;
            tx_calm      = ($urandom_range(0, 3) == 0);
            rx_calm      = ($urandom_range(0, 3) == 0);
            series_trend = trend_t'($urandom_range(0, 3));
            // fill the block while the result side holds off
            if (phase_period[ph] == MAX_PERIOD) begin
                tx_calm = 1'b1;
                rx_calm = 1'b0;
                squeeze = 1'b1;
            end
            for (k = 0; k < phase_items[ph]; k++) begin
                start = (k == 0) ? 1'($urandom_range(0, 1)) :
                        1'($urandom_range(0, 3 * span + 6) == 0);
                if (start) begin
                    series_trend = trend_t'($urandom_range(0, 3));
                end
                send_item(walk_price(), start);
            end
        end

        drain();
        repeat (DRAIN_TAIL) @(posedge aclk);
        if (mismatch_total == 0 && pending == 0) begin
            $display("relative_strength_index verification clean");
        end else begin
            $display("relative_strength_index verification failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("relative_strength_index verification failed");
        $finish;
    end

endmodule
